// ===== rtl/core/min_heap_priority_queue_defines.svh =====
// assertion macros for the heap priority queue checker
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define HMPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/hmpq_pkg.sv =====
package hmpq_pkg;

   localparam int DEF_CAPACITY  = 1024;
   localparam int DEF_KEY_WIDTH = 32;
   localparam int IO_KEY_W      = 32;
   localparam int STATUS_W      = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_LD,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_DN_CHK,
      ST_DN_CMP,
      ST_DONE
   } hmpq_state_type;

endpackage

// ===== rtl/core/hmpq_store.sv =====
module hmpq_store #(
   parameter int DEPTH = hmpq_pkg::DEF_CAPACITY,
   parameter int WIDTH = hmpq_pkg::DEF_KEY_WIDTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [WIDTH-1:0]  rd_a_data,
   output logic [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// ===== rtl/core/min_heap_priority_queue.sv =====
// Binary min-heap priority queue of signed keys.
// Request channel req_*: req_tuser[0] is the operation (0 push, 1 pop) and
// req_tdata carries the 32-bit key, ignored on a pop. One result per request
// on rsp_*: rsp_tuser is the status (ok, full, empty) and rsp_tdata packs
// popped key, current minimum, empty flag and entry count.
// The block holds one request at a time; req_tready is high only while the
// sequencer is idle. The keys live in a single memory with one write and two
// registered read ports. A push sifts up, each level a parent read and then a
// compare and write; a pop reads the last entry and sifts down, each level a
// read of both children together and then a compare and write. Refused
// requests go straight to the result.
// The result sits in an output register: a new request is taken while it
// waits, and if rsp_tready stays low the next finished result waits in the
// sequencer until the register frees up.
// Reset (synchronous) empties the heap and drops any pending result; the
// memory itself is not cleared, only entries below the count are ever used.
module min_heap_priority_queue #(
   parameter int CAPACITY  = hmpq_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = hmpq_pkg::DEF_KEY_WIDTH,
   localparam int CNT_W = $clog2(CAPACITY + 1),
   localparam int RSP_W = ((2 * hmpq_pkg::IO_KEY_W + 1 + CNT_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [hmpq_pkg::IO_KEY_W-1:0] req_tdata,  // key_in
   input  logic [0:0]                    req_tuser,  // operation
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // popped_key, min_key, empty_flag, entry_count, zero fill
   output logic [RSP_W-1:0]              rsp_tdata,
   output logic [hmpq_pkg::STATUS_W-1:0] rsp_tuser   // status
);

   import hmpq_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CHLD_W = ADDR_W + 1;

   function automatic logic key_le(input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b);
      return $signed(a) <= $signed(b);
   endfunction

   hmpq_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   logic [KEY_WIDTH-1:0]    moving_ff, moving_in;
   logic [KEY_WIDTH-1:0]    root_ff;
   logic [KEY_WIDTH-1:0]    popped_ff, popped_in;
   logic [STATUS_W-1:0]     status_ff, status_in;

   logic                    out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]     out_status_ff, out_status_in;
   logic [IO_KEY_W-1:0]     out_popped_ff, out_popped_in;
   logic [IO_KEY_W-1:0]     out_min_ff, out_min_in;
   logic [CNT_W-1:0]        out_count_ff, out_count_in;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [KEY_WIDTH-1:0]    wr_data;
   logic [ADDR_W-1:0]       rd_a_addr;
   logic [ADDR_W-1:0]       rd_b_addr;
   logic [KEY_WIDTH-1:0]    rd_a_data;
   logic [KEY_WIDTH-1:0]    rd_b_data;

   logic [ADDR_W-1:0]       parent;
   logic [CHLD_W-1:0]       child_a;
   logic [CHLD_W-1:0]       child_b;
   logic                    has_child;
   logic                    has_right;
   logic                    pick_right;
   logic [KEY_WIDTH-1:0]    pick_key;
   logic [ADDR_W-1:0]       pick_pos;
   logic                    accept;
   logic                    out_free;

   hmpq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign accept   = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   // heap index arithmetic, count_ff already holds the size during a walk
   assign parent     = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
   assign child_a    = {pos_ff, 1'b1};
   assign child_b    = child_a + CHLD_W'(1);
   assign has_child  = child_a < CHLD_W'(count_ff);
   assign has_right  = child_b < CHLD_W'(count_ff);
   assign pick_right = has_right && !key_le(rd_a_data, rd_b_data);
   assign pick_key   = pick_right ? rd_b_data : rd_a_data;
   assign pick_pos   = pick_right ? child_b[ADDR_W-1:0] : child_a[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      moving_ff     <= moving_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_popped_ff <= out_popped_in;
      out_min_ff    <= out_min_in;
      out_count_ff  <= out_count_in;
      // shadow copy of the root for pops and the reported minimum
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      moving_in     = moving_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_popped_in = out_popped_ff;
      out_min_in    = out_min_ff;
      out_count_in  = out_count_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = moving_ff;
      rd_a_addr     = child_a[ADDR_W-1:0];
      rd_b_addr     = child_b[ADDR_W-1:0];
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            // last entry, needed by a pop
            rd_a_addr  = ADDR_W'(count_ff - CNT_W'(1));
            if (accept) begin
               status_in = STATUS_OK;
               popped_in = '0;
               if (req_tuser[0] == OP_PUSH) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     moving_in = KEY_WIDTH'($signed(req_tdata));
                     pos_in    = ADDR_W'(count_ff);
                     count_in  = count_ff + CNT_W'(1);
                     state_in  = ST_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     popped_in = root_ff;
                     count_in  = count_ff - CNT_W'(1);
                     state_in  = (count_ff == CNT_W'(1)) ? ST_DONE : ST_POP_LD;
                  end
               end
            end
         end
         ST_POP_LD: begin
            moving_in = rd_a_data;
            pos_in    = '0;
            state_in  = ST_DN_CHK;
         end
         ST_UP_CHK: begin
            rd_a_addr = parent;
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (key_le(rd_a_data, moving_ff)) begin
               state_in = ST_DONE;
            end else begin
               wr_data  = rd_a_data;
               pos_in   = parent;
               state_in = ST_UP_CHK;
            end
         end
         ST_DN_CHK: begin
            if (!has_child) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (key_le(moving_ff, pick_key)) begin
               state_in = ST_DONE;
            end else begin
               wr_data  = pick_key;
               pos_in   = pick_pos;
               state_in = ST_DN_CHK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_popped_in = IO_KEY_W'(popped_ff);
               out_min_in    = (count_ff != '0) ? IO_KEY_W'(root_ff) : '0;
               out_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = RSP_W'({out_count_ff, (out_count_ff == '0), out_min_ff, out_popped_ff});

endmodule

// ===== rtl/core/hmpq_checker.sv =====
`include "min_heap_priority_queue_defines.svh"

module hmpq_checker #(
   parameter int CNT_W = $clog2(hmpq_pkg::DEF_CAPACITY + 1),
   parameter int RSP_W = 80
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [RSP_W-1:0]              rsp_tdata,
   input logic [hmpq_pkg::STATUS_W-1:0] rsp_tuser
);

   import hmpq_pkg::*;

   localparam int EMPTY_BIT = 2 * IO_KEY_W;
   localparam int CNT_LO    = EMPTY_BIT + 1;

   logic [CNT_W-1:0] rsp_count;

   assign rsp_count = rsp_tdata[CNT_LO +: CNT_W];

   `HMPQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled result transaction changed")

   `HMPQ_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready,
      "request taken while the previous one is still in work")

   `HMPQ_ASSERT_NOW(a_status_code, rsp_tvalid, rsp_tuser != STATUS_BAD,
      "undefined status code")

   `HMPQ_ASSERT_NOW(a_empty_flag, rsp_tvalid,
      rsp_tdata[EMPTY_BIT] == (rsp_count == '0), "empty flag disagrees with count")

   `HMPQ_ASSERT_NOW(a_refused_zero, rsp_tvalid && rsp_tuser != STATUS_OK,
      rsp_tdata[IO_KEY_W-1:0] == '0, "refused transaction reports a popped key")

endmodule

bind min_heap_priority_queue hmpq_checker #(
   .CNT_W (CNT_W),
   .RSP_W (RSP_W)
) u_hmpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/min_heap_priority_queue_test.sv =====
module min_heap_priority_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hmpq_pkg::*;

   localparam int CAPACITY       = DEF_CAPACITY;
   localparam int CNT_W          = $clog2(CAPACITY + 1);
   localparam int RSP_W          = ((2 * IO_KEY_W + 1 + CNT_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS   = 540;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef logic signed [DEF_KEY_WIDTH-1:0] heap_key_type;

   typedef struct {
      logic [STATUS_W-1:0]        status;
      logic signed [IO_KEY_W-1:0] popped_key;
      logic signed [IO_KEY_W-1:0] min_key;
      logic                       empty_flag;
      logic [CNT_W-1:0]           entry_count;
   } heap_result_type;

   // tracks the heap contents and the results still owed by the block
   class heap_scoreboard;
      heap_key_type    keys [CAPACITY];
      int              fill;
      heap_result_type owed_results [$];
      int              error_count;

      function new();
         fill        = 0;
         error_count = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function void note_request(logic op, logic [IO_KEY_W-1:0] key_in);
         heap_result_type r;
         heap_key_type    moving;
         int              pos;
         int              parent;
         int              child;
         r.status     = STATUS_OK;
         r.popped_key = '0;
         if (op == OP_PUSH) begin
            if (fill >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               moving = heap_key_type'($signed(key_in));
               pos    = fill;
               // equal parent stops the walk
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (keys[parent] <= moving) break;
                  keys[pos] = keys[parent];
                  pos       = parent;
               end
               keys[pos] = moving;
               fill++;
            end
         end else begin
            if (fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.popped_key = keys[0][IO_KEY_W-1:0];
               fill--;
               moving = keys[fill];
               pos    = 0;
               child  = 1;
               while (child < fill) begin
                  // left child wins a tie
                  if (child + 1 < fill && keys[child + 1] < keys[child]) child++;
                  if (moving <= keys[child]) break;
                  keys[pos] = keys[child];
                  pos       = child;
                  child     = 2 * pos + 1;
               end
               keys[pos] = moving;
            end
         end
         r.min_key     = (fill > 0) ? keys[0][IO_KEY_W-1:0] : '0;
         r.empty_flag  = (fill == 0);
         r.entry_count = fill[CNT_W-1:0];
         owed_results.push_back(r);
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [RSP_W-1:0] data);
         heap_result_type r;
         if (owed_results.size() == 0) begin
            $error("result transaction arrived with none outstanding");
            error_count++;
            return;
         end
         r = owed_results.pop_front();
         compare_field("status", r.status, status);
         compare_field("popped_key", r.popped_key, $signed(data[IO_KEY_W-1:0]));
         compare_field("min_key", r.min_key, $signed(data[2*IO_KEY_W-1:IO_KEY_W]));
         compare_field("empty_flag", r.empty_flag, data[2*IO_KEY_W]);
         compare_field("entry_count", r.entry_count, data[2*IO_KEY_W+CNT_W:2*IO_KEY_W+1]);
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [IO_KEY_W-1:0]       req_tdata  = '0;
   logic [0:0]                req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_W-1:0]          rsp_tdata;
   logic [STATUS_W-1:0]       rsp_tuser;

   heap_scoreboard sb = new();
   int  queue_depth;
   int  idle_cycles;
   bit  steady_req;
   bit  steady_rsp;

   min_heap_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, with occasional stretches of none
   initial begin
      int stall;
      steady_rsp = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0) steady_rsp = !steady_rsp;
         stall = steady_rsp ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [IO_KEY_W-1:0] pick_key();
      logic [IO_KEY_W-1:0] k;
      case ($urandom_range(0, 7))
         0, 1, 2: k = $urandom();
         // narrow range so equal keys are common
         3, 4:    k = $urandom_range(0, 16) - 8;
         5: begin
            case ($urandom_range(0, 3))
               0: k = 32'h7FFF_FFFF;
               1: k = 32'h8000_0000;
               2: k = 32'h0000_0000;
               default: k = 32'hFFFF_FFFF;
            endcase
         end
         default: k = {($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      endcase
      return k;
   endfunction

   task automatic send_request(logic op, logic [IO_KEY_W-1:0] key);
      int gap;
      if ($urandom_range(0, 39) == 0) steady_req = !steady_req;
      gap = steady_req ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= op;
      req_tdata    <= key;
      do @(posedge clock); while (!req_tready);
      if (op == OP_PUSH) begin
         if (queue_depth < CAPACITY) queue_depth++;
      end else if (queue_depth > 0) begin
         queue_depth--;
      end
   endtask

   initial begin
      int push_pct;
      queue_depth = 0;
      steady_req  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, extreme keys, ties, full drain
      send_request(OP_POP, 32'hFFFF_FFFF);
      send_request(OP_PUSH, 32'h7FFF_FFFF);
      send_request(OP_PUSH, 32'h8000_0000);
      send_request(OP_PUSH, 32'h0000_0000);
      send_request(OP_PUSH, 32'hFFFF_FFFF);
      send_request(OP_PUSH, 32'h0000_0000);
      send_request(OP_PUSH, 32'h0000_0001);
      send_request(OP_PUSH, 32'h5555_5555);
      send_request(OP_PUSH, 32'hAAAA_AAAA);
      repeat (8) send_request(OP_POP, 32'h0000_0000);
      send_request(OP_POP, 32'h1234_5678);
      repeat (3) send_request(OP_PUSH, 32'h0000_0005);
      repeat (3) send_request(OP_POP, $urandom());

      // random mix with a drifting push ratio
      push_pct = 50;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 75;
               1: push_pct = 50;
               default: push_pct = 25;
            endcase
         end
         if ($urandom_range(0, 99) < push_pct) send_request(OP_PUSH, pick_key());
         else send_request(OP_POP, $urandom());
      end

      // drain past empty
      while (queue_depth > 0) send_request(OP_POP, $urandom());
      repeat (2) send_request(OP_POP, $urandom());

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
